>>> src/lud_pkg.sv
// ----------------------------------------------------------------------------
// lud_pkg
// Shared types, constants and byte classification for the lenient UTF-8
// decoder.
// ----------------------------------------------------------------------------
package lud_pkg;

  localparam int unsigned LUD_QUEUE_DEPTH = 2;
  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] BAD_CP = CP_W'(63);  // '?'

  // sequence lengths implied by a first byte
  localparam logic [2:0] LEN_BAD   = 3'd0;
  localparam logic [2:0] LEN_ASCII = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  localparam logic [7:0] MASK_80 = 8'h80;
  localparam logic [7:0] MASK_E0 = 8'hE0;
  localparam logic [7:0] LEAD_C0 = 8'hC0;
  localparam logic [7:0] MASK_F0 = 8'hF0;
  localparam logic [7:0] LEAD_E0 = 8'hE0;
  localparam logic [7:0] MASK_F8 = 8'hF8;
  localparam logic [7:0] LEAD_F0 = 8'hF0;

  // one unit of work for the back end: up to four bytes decoded as a
  // self-contained run
  typedef struct packed {
    logic [3:0][7:0] data;  // data[0] is the oldest byte
    logic [2:0]      len;   // 1..4
    logic            fin;   // run ends the string
  } job_t;

  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] s;
    if ((b & MASK_80) == 8'h00)         s = LEN_ASCII;
    else if ((b & MASK_E0) == LEAD_C0) s = LEN_TWO;
    else if ((b & MASK_F0) == LEAD_E0) s = LEN_THREE;
    else if ((b & MASK_F8) == LEAD_F0) s = LEN_FOUR;
    else                               s = LEN_BAD;
    return s;
  endfunction

endpackage

>>> src/lenient_utf8_decoder_unit.sv
// ----------------------------------------------------------------------------
// lenient_utf8_decoder_unit
// Lenient UTF-8 decoder: one byte in per item, code points out.
// ----------------------------------------------------------------------------
// Result path: a job is registered in a queue slot, then the back end
//   loads the output register; the front end is combinational into the queue.
// Throughput: one byte per cycle while the job queue has room; a string end
//   flushing k held bytes emits up to k + 1 code points, one per cycle in
//   the back end while the output register is free or popped.
// Reset: synchronous, clears the gather state, the job queue and the back
//   end's position and valid flag; held bytes and output data are not cleared.
// ----------------------------------------------------------------------------
module lenient_utf8_decoder_unit import lud_pkg::*; #(
  parameter int unsigned QueueDepth = LUD_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  // input side
  input  logic            push,
  output logic            full,
  input  logic [7:0]      byte_in,
  input  logic            final_byte,
  // result side
  output logic            empty,
  input  logic            pop,
  output logic [CP_W-1:0] code_point,
  output logic            run_last,
  output logic            text_end
);

  logic accept;
  logic job_push;
  job_t job;
  logic q_full;
  logic q_empty;
  logic q_pop;
  job_t head;

  // The front end only stalls on a full job queue. Bytes that are merely
  // held (lead and middle bytes) never enter the queue.
  assign full   = q_full;
  assign accept = push && !q_full;

  lud_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .byte_in    (byte_in),
    .final_byte (final_byte),
    .job_push   (job_push),
    .job        (job)
  );

  // Decouples classification from emission, so a multi-result flush in the
  // back end does not immediately stall the input side.
  lud_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_job  (job),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_job  (head),
    .q_empty (q_empty)
  );

  // Back end: one code point per cycle while the output is free or popped,
  // from the head job into a single output register acting as result queue.
  lud_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .head       (head),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .code_point (code_point),
    .run_last   (run_last),
    .text_end   (text_end)
  );

endmodule

>>> src/lud_front.sv
// ----------------------------------------------------------------------------
// lud_front
// Takes bytes, tracks a partly gathered sequence and hands complete runs
// to the job queue.
// ----------------------------------------------------------------------------
module lud_front import lud_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] byte_in,
  input  logic       final_byte,
  output logic       job_push,
  output job_t       job
);

  logic [2:0][7:0] held_bytes;
  logic [1:0]      held_count;
  logic [2:0]      needed_total;
  logic [2:0]      s;
  logic            completes;

  always_comb begin
    s = seq_len(byte_in);
    job.data[0] = (held_count == 2'd0) ? byte_in : held_bytes[0];
    job.data[1] = (held_count == 2'd1) ? byte_in : held_bytes[1];
    job.data[2] = (held_count == 2'd2) ? byte_in : held_bytes[2];
    job.data[3] = byte_in;
    job.len     = {1'b0, held_count} + 3'd1;
    job.fin     = final_byte;
    completes   = (held_count != 2'd0) && (job.len >= needed_total);
    job_push    = accept && (final_byte || completes ||
                             ((held_count == 2'd0) && (s < LEN_TWO)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count   <= 2'd0;
      needed_total <= 3'd0;
    end else if (accept) begin
      if (final_byte || completes) begin
        held_count   <= 2'd0;
        needed_total <= 3'd0;
      end else if (held_count == 2'd0) begin
        if (s >= LEN_TWO) begin
          held_count   <= 2'd1;
          needed_total <= s;
        end
      end else begin
        held_count <= held_count + 2'd1;
      end
    end
  end

  // held bytes carry no reset
  always_ff @(posedge clk) begin
    if (accept && !final_byte && !completes) begin
      if (held_count == 2'd0) begin
        if (s >= LEN_TWO) held_bytes[0] <= byte_in;
      end else begin
        held_bytes[held_count] <= byte_in;
      end
    end
  end

endmodule

>>> src/lud_queue.sv
// ----------------------------------------------------------------------------
// lud_queue
// Small register FIFO of jobs between front and back end.
// ----------------------------------------------------------------------------
module lud_queue import lud_pkg::*; #(
  parameter int unsigned Depth = LUD_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_job,
  output logic q_full,
  input  logic rd_en,
  output job_t rd_job,
  output logic q_empty
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LAST = AW'(Depth - 1);

  job_t          slots [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign q_full  = (count == CW'(Depth));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      if (do_wr && !do_rd)      count <= count + CW'(1);
      else if (do_rd && !do_wr) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_job;
  end

endmodule

>>> src/lud_back.sv
// ----------------------------------------------------------------------------
// lud_back
// Head job to output register: one code point per cycle if free or popped.
// ----------------------------------------------------------------------------
module lud_back import lud_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  job_t            head,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output logic [CP_W-1:0] code_point,
  output logic            run_last,
  output logic            text_end
);

  logic [2:0]      pos;
  logic            out_valid;
  logic [3:0][7:0] w;
  logic [2:0]      s;
  logic [2:0]      step;
  logic [2:0]      pos_next;
  logic [CP_W-1:0] cp;
  logic            fits;
  logic            last;
  logic            advance;

  always_comb begin
    logic [2:0] idx;
    for (int k = 0; k < 4; k++) begin
      idx  = {1'b0, pos[1:0]} + 3'(k);
      w[k] = idx[2] ? 8'h00 : head.data[idx[1:0]];
    end
    s    = seq_len(w[0]);
    fits = ({1'b0, pos} + {1'b0, s}) <= {1'b0, head.len};
    step = 3'd1;
    if (s == LEN_ASCII) begin
      cp = CP_W'(w[0][6:0]);
    end else if ((s >= LEN_TWO) && fits) begin
      step = s;
      if (s == LEN_TWO)        cp = CP_W'({w[0][4:0], w[1][5:0]});
      else if (s == LEN_THREE) cp = CP_W'({w[0][3:0], w[1][5:0], w[2][5:0]});
      else                     cp = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
    end else begin
      cp = BAD_CP;
    end
    pos_next = pos + step;
    last     = (pos_next >= head.len);
  end

  assign advance = !out_valid || pop;
  assign q_pop   = advance && !q_empty && last;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 3'd0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= !q_empty;
      if (!q_empty) pos <= last ? 3'd0 : pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !q_empty) begin
      code_point <= cp;
      run_last   <= last;
      text_end   <= last && head.fin;
    end
  end

endmodule
